[rtl/lpdh_pkg.sv]
// ----------------------------------------------------------------------------
// lpdh_pkg: shared types and constants for the line pair distance histogram
// Widths of the line, the counters and the control bundle of the cell chain.
// ----------------------------------------------------------------------------
package lpdh_pkg;

   localparam int LINE_LEN  = 64;
   localparam int NUM_CELLS = LINE_LEN;
   localparam int LEN_W     = 7;
   localparam int IDX_W     = 6;
   localparam int CNT_W     = 7;

   localparam logic [LEN_W-1:0] LEN_MIN   = LEN_W'(2);
   localparam logic [LEN_W-1:0] LEN_MAX   = LEN_W'(LINE_LEN);
   localparam logic [CNT_W-1:0] CNT_SAT   = {CNT_W{1'b1}};

   typedef logic [CNT_W-1:0] cnt_type;

   // per-cycle control broadcast to every cell of the chain
   typedef struct packed {
      logic black;     // black pixel accepted this cycle
      logic advance;   // pixel accepted: history moves one cell on
      logic line_end;  // final pixel of the line accepted
      logic shift;     // readout step: counters and snapshots move
      logic clear;     // wipe history and counters
   } cell_ctrl_type;

endpackage

[rtl/lpdh_cell.sv]
// ----------------------------------------------------------------------------
// lpdh_cell: one distance cell of the histogram chain
// Holds one history pixel, the unfolded pair count for its distance and a
// readout snapshot. Counters shift down and snapshots shift up at readout.
// ----------------------------------------------------------------------------
module lpdh_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  lpdh_pkg::cell_ctrl_type ctrl,
   input  logic                   hist_prev,      // history bit from lower neighbor
   input  logic                   match_prev,     // pixel at this cell's distance
   input  lpdh_pkg::cnt_type      cnt_above,      // counter of upper neighbor
   input  lpdh_pkg::cnt_type      cnt_next_above, // next counter of upper neighbor
   input  lpdh_pkg::cnt_type      snap_below,     // snapshot of lower neighbor
   output logic                   hist_q,
   output lpdh_pkg::cnt_type      cnt_q,
   output lpdh_pkg::cnt_type      cnt_next,
   output lpdh_pkg::cnt_type      snap_q
);

   logic              hist_ff, hist_in;
   lpdh_pkg::cnt_type cnt_ff, cnt_in;
   lpdh_pkg::cnt_type snap_ff, snap_in;

   always_comb begin
      hist_in = hist_ff;
      if (ctrl.clear || ctrl.line_end) begin
         hist_in = 1'b0;
      end else if (ctrl.advance) begin
         hist_in = hist_prev;
      end

      cnt_in = cnt_ff;
      if (ctrl.clear) begin
         cnt_in = '0;
      end else if (ctrl.shift) begin
         cnt_in = cnt_above;
      end else if (ctrl.black && match_prev && (cnt_ff != lpdh_pkg::CNT_SAT)) begin
         cnt_in = cnt_ff + lpdh_pkg::CNT_W'(1);
      end

      // snapshot is offset by one cell: it takes the upper neighbor's count
      snap_in = snap_ff;
      if (ctrl.line_end) begin
         snap_in = cnt_next_above;
      end else if (ctrl.shift) begin
         snap_in = snap_below;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         hist_ff <= hist_in;
         cnt_ff  <= cnt_in;
      end
      snap_ff <= snap_in;
   end

   assign hist_q   = hist_ff;
   assign cnt_q    = cnt_ff;
   assign cnt_next = cnt_in;
   assign snap_q   = snap_ff;

endmodule

[rtl/line_pair_distance_histogram.sv]
// ----------------------------------------------------------------------------
// line_pair_distance_histogram: folded pair distance histogram of a pixel line
// Chain of distance cells counts black pixel pairs per distance as pixels
// stream in; after each line the folded histogram is read out as one run.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one pixel per transaction (tdata bit 0, 1 = black).
//   rsp_*  : one bin per transaction, bins 0..ceil(len/2) in order, tlast on
//            the final bin of the line.
//   csr_*  : write of line_length (pixels per line, saturated to 2..64);
//            a write also restarts the line. Write only while idle.
// Throughput: one pixel per cycle while a line fills; every distance cell
//   updates its counter in the same cycle, so the chain sets no limit.
// Readout: after the final pixel is accepted the bins are read out as one
//   run, one bin per cycle while rsp_tready allows, set by the shifting
//   counter chain; req_tready is low until the final bin sits in the output
//   register.
// Stall: while rsp_tready is low the output register holds and the chain
//   pauses; nothing is dropped.
// Reset: line_length returns to 64, history, counters and position clear,
//   no results pending.
// ----------------------------------------------------------------------------
module line_pair_distance_histogram (
   input  logic        clock,
   input  logic        reset,
   // input pixels
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [0] pixel, [7:1] zero
   // histogram bins
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [5:0] bin_index, [12:6] pair_count, [15:13] zero
   output logic        rsp_tlast,   // last_bin
   // configuration
   input  logic        csr_we,
   input  logic [6:0]  csr_wdata    // line_length
);

   localparam int NC    = lpdh_pkg::NUM_CELLS;
   localparam int LEN_W = lpdh_pkg::LEN_W;
   localparam int IDX_W = lpdh_pkg::IDX_W;
   localparam int CNT_W = lpdh_pkg::CNT_W;

   // control and readout registers
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [IDX_W-1:0]  pos_ff, pos_in;
   logic              busy_ff, busy_in;       // readout of a line in progress
   logic [IDX_W-1:0]  k_ff, k_in;             // bin being read out
   logic              rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]  rsp_index_ff, rsp_index_in;
   lpdh_pkg::cnt_type rsp_count_ff, rsp_count_in;
   logic              rsp_last_ff, rsp_last_in;

   logic [LEN_W-1:0]  eff_len;
   logic [LEN_W-1:0]  len_m1;
   logic [IDX_W-1:0]  half;
   logic [LEN_W:0]    len_p1;
   logic [IDX_W-1:0]  last_k;
   logic              accept;
   logic              line_end;
   logic              step;
   logic              step_last;
   lpdh_pkg::cnt_type near_term;
   lpdh_pkg::cnt_type far_term;
   logic [CNT_W:0]    bin_sum;
   lpdh_pkg::cnt_type bin_count;

   lpdh_pkg::cell_ctrl_type ctrl;

   // chain wiring
   logic              hist_w     [NC];
   lpdh_pkg::cnt_type cnt_w      [NC];
   lpdh_pkg::cnt_type cnt_next_w [NC];
   lpdh_pkg::cnt_type snap_w     [NC];

   // effective line length and derived limits
   always_comb begin
      if (len_ff < lpdh_pkg::LEN_MIN) begin
         eff_len = lpdh_pkg::LEN_MIN;
      end else if (len_ff > lpdh_pkg::LEN_MAX) begin
         eff_len = lpdh_pkg::LEN_MAX;
      end else begin
         eff_len = len_ff;
      end
   end

   assign len_m1 = eff_len - LEN_W'(1);
   assign half   = eff_len[LEN_W-1:1];
   assign len_p1 = {1'b0, eff_len} + (LEN_W+1)'(1);
   assign last_k = len_p1[IDX_W:1];      // ceil(len/2)

   assign req_tready = !busy_ff;
   assign accept     = req_tvalid && !busy_ff;
   assign line_end   = accept && ({1'b0, pos_ff} == len_m1);

   // one readout step whenever the output register is free or being drained
   assign step      = busy_ff && (!rsp_valid_ff || rsp_tready);
   assign step_last = step && (k_ff == last_k);

   assign ctrl.black    = accept && req_tdata[0];
   assign ctrl.advance  = accept;
   assign ctrl.line_end = line_end;
   assign ctrl.shift    = step;
   assign ctrl.clear    = step_last || csr_we;

   // Bin k folds distance k (only below the half length) and distance len-k.
   // The down-shifting counters put distance k in cell 0; the up-shifting
   // snapshots, loaded one cell low, put distance len-k in cell len-1.
   assign near_term = (k_ff < half) ? cnt_w[0] : '0;
   assign far_term  = snap_w[len_m1[IDX_W-1:0]];
   assign bin_sum   = {1'b0, near_term} + {1'b0, far_term};
   assign bin_count = bin_sum[CNT_W] ? lpdh_pkg::CNT_SAT : bin_sum[CNT_W-1:0];

   for (genvar i = 0; i < NC; i++) begin : g_cell
      logic              hist_prev_w;
      logic              match_prev_w;
      lpdh_pkg::cnt_type cnt_above_w;
      lpdh_pkg::cnt_type cnt_next_above_w;
      lpdh_pkg::cnt_type snap_below_w;

      if (i == 0) begin : g_first
         // distance zero: the pixel pairs with itself
         assign hist_prev_w  = req_tdata[0];
         assign match_prev_w = 1'b1;
         assign snap_below_w = '0;
      end else begin : g_rest
         assign hist_prev_w  = hist_w[i-1];
         assign match_prev_w = hist_w[i-1];
         assign snap_below_w = snap_w[i-1];
      end

      if (i == NC-1) begin : g_top
         assign cnt_above_w      = '0;
         assign cnt_next_above_w = '0;
      end else begin : g_mid
         assign cnt_above_w      = cnt_w[i+1];
         assign cnt_next_above_w = cnt_next_w[i+1];
      end

      lpdh_cell u_cell (
         .clock          (clock),
         .reset          (reset),
         .ctrl           (ctrl),
         .hist_prev      (hist_prev_w),
         .match_prev     (match_prev_w),
         .cnt_above      (cnt_above_w),
         .cnt_next_above (cnt_next_above_w),
         .snap_below     (snap_below_w),
         .hist_q         (hist_w[i]),
         .cnt_q          (cnt_w[i]),
         .cnt_next       (cnt_next_w[i]),
         .snap_q         (snap_w[i])
      );
   end

   always_comb begin
      len_in       = len_ff;
      pos_in       = pos_ff;
      busy_in      = busy_ff;
      k_in         = k_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_index_in = rsp_index_ff;
      rsp_count_in = rsp_count_ff;
      rsp_last_in  = rsp_last_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      if (step) begin
         rsp_valid_in = 1'b1;
         rsp_index_in = k_ff;
         rsp_count_in = bin_count;
         rsp_last_in  = step_last;
         k_in         = k_ff + IDX_W'(1);
         if (step_last) begin
            busy_in = 1'b0;
         end
      end

      if (accept) begin
         if (line_end) begin
            pos_in  = '0;
            busy_in = 1'b1;
            k_in    = '0;
         end else begin
            pos_in = pos_ff + IDX_W'(1);
         end
      end

      if (csr_we) begin
         len_in  = csr_wdata;
         pos_in  = '0;
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= lpdh_pkg::LEN_MAX;
         pos_ff       <= '0;
         busy_ff      <= 1'b0;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         len_ff       <= len_in;
         pos_ff       <= pos_in;
         busy_ff      <= busy_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_index_ff <= rsp_index_in;
      rsp_count_ff <= rsp_count_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_count_ff, rsp_index_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

[rtl/lpdh_checker.sv]
// ----------------------------------------------------------------------------
// lpdh_checker: port-level checks for the line pair distance histogram
// Watches the response run ordering and the input hold-off during readout.
// ----------------------------------------------------------------------------
module lpdh_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic        rsp_tlast
);

   // a stalled bin holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled response changed");

   // no pixel taken while a run is still being read out
   a_no_input_in_run: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> !req_tready)
      else $error("input ready during histogram readout");

   // bins of a run count up by one
   a_bin_order: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !$past(reset) &&
         $past(rsp_tvalid && rsp_tready && !rsp_tlast) |->
         rsp_tdata[5:0] == $past(rsp_tdata[5:0]) + 6'd1)
      else $error("bin index out of order");

   // a run opens at bin zero
   a_run_start: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !$past(reset) && $past(rsp_tvalid && rsp_tready && rsp_tlast) |->
         rsp_tdata[5:0] == 6'd0)
      else $error("run does not start at bin zero");

   // bin index never beyond the largest folded distance
   a_bin_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[5:0] <= 6'd32)
      else $error("bin index out of range");

endmodule

bind line_pair_distance_histogram lpdh_checker u_lpdh_checker (.*);

[bench/line_pair_distance_histogram_checker.sv]
// ----------------------------------------------------------------------------
// line_pair_distance_histogram_checker: scoreboard for the pair histogram
// Watches the pixel, bin and csr ports and keeps its own copy of the line
// state. It predicts each bin run and compares every bin transaction,
// field by field, in order.
// ----------------------------------------------------------------------------
module line_pair_distance_histogram_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,   // [0] pixel
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,   // [5:0] bin_index, [12:6] pair_count
   input  logic        rsp_tlast,   // last_bin
   input  logic        csr_we,
   input  logic [6:0]  csr_wdata,   // line_length
   output int          error_count,
   output int          bins_pending
);

   localparam int NUM_BINS = (lpdh_pkg::LINE_LEN + 1) / 2 + 1;

   typedef struct packed {
      logic [lpdh_pkg::IDX_W-1:0] bin_index;
      lpdh_pkg::cnt_type          pair_count;
      logic                       last_bin;
   } hist_bin_type;

   logic [lpdh_pkg::LEN_W-1:0]    length_reg = lpdh_pkg::LEN_MAX;
   logic [lpdh_pkg::LINE_LEN-1:0] black_seen = '0;
   lpdh_pkg::cnt_type             pair_hist [NUM_BINS];
   int unsigned                   next_pos   = 0;
   hist_bin_type                  bins_due [$];
   int                            mismatches = 0;

   function automatic int unsigned line_span();
      if (length_reg < lpdh_pkg::LEN_MIN) return lpdh_pkg::LEN_MIN;
      if (length_reg > lpdh_pkg::LEN_MAX) return lpdh_pkg::LEN_MAX;
      return length_reg;
   endfunction

   task automatic restart_line();
      black_seen = '0;
      for (int k = 0; k < NUM_BINS; k++) pair_hist[k] = '0;
      next_pos = 0;
   endtask

   // one accepted pixel: count its pairs, emit the run after the final one
   task automatic add_pixel(input logic black);
      int unsigned  span, half, pos, gap, nb;
      hist_bin_type b;
      span = line_span();
      half = span / 2;
      pos  = next_pos;
      if (pos >= span) pos = span - 1;
      if (black) begin
         black_seen[pos] = 1'b1;
         for (int j = 0; j <= pos; j++) begin
            if (black_seen[j]) begin
               gap = pos - j;
               if (gap >= half) gap = span - gap;
               if (gap < NUM_BINS && pair_hist[gap] != lpdh_pkg::CNT_SAT)
                  pair_hist[gap] = pair_hist[gap] + 1'b1;
            end
         end
      end
      if (pos + 1 < span) begin
         next_pos = pos + 1;
      end else begin
         nb = (span + 1) / 2 + 1;
         for (int k = 0; k < nb; k++) begin
            b.bin_index  = lpdh_pkg::IDX_W'(k);
            b.pair_count = pair_hist[k];
            b.last_bin   = (k + 1 == nb);
            bins_due.push_back(b);
         end
         restart_line();
      end
   endtask

   always @(posedge clock) begin
      hist_bin_type got, want;
      if (reset) begin
         length_reg = lpdh_pkg::LEN_MAX;
         restart_line();
         bins_due.delete();
      end else begin
         if (csr_we) begin
            length_reg = csr_wdata;
            restart_line();
         end
         if (req_tvalid && req_tready) add_pixel(req_tdata[0]);
         if (rsp_tvalid && rsp_tready) begin
            got.bin_index  = rsp_tdata[5:0];
            got.pair_count = rsp_tdata[12:6];
            got.last_bin   = rsp_tlast;
            if (bins_due.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: unexpected bin: index %0d count %0d last %0b",
                           $realtime, got.bin_index, got.pair_count, got.last_bin);
            end else begin
               want = bins_due.pop_front();
               if (got.bin_index != want.bin_index || got.pair_count != want.pair_count
                   || got.last_bin != want.last_bin) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("%0t: bin mismatch: exp index %0d count %0d last %0b, %s",
                              $realtime, want.bin_index, want.pair_count, want.last_bin,
                              $sformatf("got index %0d count %0d last %0b",
                                        got.bin_index, got.pair_count, got.last_bin));
               end
            end
         end
      end
      error_count  <= mismatches;
      bins_pending <= bins_due.size();
   end

endmodule

[bench/tb_line_pair_distance_histogram.sv]
// ----------------------------------------------------------------------------
// tb_line_pair_distance_histogram: stimulus and verdict for the pair histogram
// Streams pixel lines at many line lengths, directed corner lines first and
// then random lines, under three idle patterns. A separate checker predicts
// and compares every bin; this module only drives and reports.
// ----------------------------------------------------------------------------
module tb_line_pair_distance_histogram;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = '0;    // [0] pixel, [7:1] zero
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;          // [5:0] bin_index, [12:6] pair_count, [15:13] zero
   logic        rsp_tlast;          // last_bin
   logic        csr_we     = 1'b0;
   logic [6:0]  csr_wdata  = '0;    // line_length

   int          error_count;
   int          bins_pending;

   // idle odds in percent, changed per phase
   int unsigned send_idle_pct = 6;
   int unsigned recv_idle_pct = 79;
   // effective line length as the block sees it (reset value 64)
   int unsigned cur_len       = lpdh_pkg::LINE_LEN;

   line_pair_distance_histogram u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   line_pair_distance_histogram_checker u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tlast    (rsp_tlast),
      .csr_we       (csr_we),
      .csr_wdata    (csr_wdata),
      .error_count  (error_count),
      .bins_pending (bins_pending)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // receiver backpressure: a fresh coin every cycle
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // One pixel transaction. tvalid stays high between back-to-back pixels;
   // it only drops when a gap is drawn, so it is never lowered and raised in
   // the same step.
   task automatic send_pixel(input logic black);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'd0, black};
      do @(posedge clock); while (!req_tready);
   endtask

   // directed pixels, bit 0 first
   task automatic send_pattern(input logic [7:0] bits, input int unsigned count);
      for (int i = 0; i < count; i++) send_pixel(bits[i]);
   endtask

   // random pixels, density in percent black
   task automatic send_pixels(input int unsigned count, input int unsigned density);
      for (int i = 0; i < count; i++) send_pixel($urandom_range(99) < density);
   endtask

   // Length write only while idle: bin count is registered behind the final
   // pixel, so settle a little before trusting it, then drain, then pause
   // for any pixel still moving through the chain.
   task automatic write_length(input logic [6:0] value);
      req_tvalid <= 1'b0;
      repeat (2) @(posedge clock);
      while (bins_pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      cur_len = (value < lpdh_pkg::LEN_MIN) ? lpdh_pkg::LEN_MIN :
                (value > lpdh_pkg::LEN_MAX) ? lpdh_pkg::LEN_MAX : value;
   endtask

   initial begin
      int unsigned sent, lines, density;
      logic [6:0]  raw;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // ---- directed corners ----
      // partial line at the reset length, then a write restarts the line
      send_pattern(8'b111, 3);
      write_length(7'd2);
      send_pattern(8'b11, 2);        // shortest line, both black
      write_length(7'd0);            // below range: saturates to 2
      send_pattern(8'b10, 2);
      write_length(7'd1);
      send_pattern(8'b01, 2);
      write_length(7'd3);            // odd length: half bin present
      send_pattern(8'b101, 3);
      write_length(7'd5);
      send_pattern(8'b11111, 5);     // all black
      write_length(7'd4);
      send_pattern(8'b0000, 4);      // all white: empty histogram
      write_length(7'd127);          // above range: saturates to 64

      // ---- random lines, three idle patterns ----
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin send_idle_pct = 6;  recv_idle_pct = 79; end
            1: begin send_idle_pct = 79; recv_idle_pct = 6;  end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         sent = 0;
         if (phase == 0) begin
            // full-length all-black line: the largest counts
            send_pixels(cur_len, 100);
            sent = cur_len;
         end
         while (sent < 100) begin
            if ($urandom_range(4) == 0) raw = 7'($urandom_range(127));
            else raw = 7'($urandom_range(lpdh_pkg::LEN_MIN, lpdh_pkg::LEN_MAX));
            write_length(raw);
            lines = $urandom_range(1, 3);
            for (int n = 0; n < lines && sent < 100; n++) begin
               case ($urandom_range(3))
                  0: density = 0;
                  1: density = 100;
                  default: density = $urandom_range(1, 99);
               endcase
               send_pixels(cur_len, density);
               sent += cur_len;
            end
            // now and then a broken line, cut short by the next length write
            if (sent < 100 && $urandom_range(5) == 0) begin
               lines = $urandom_range(1, cur_len - 1);
               send_pixels(lines, 50);
               sent += lines;
            end
         end
      end

      // ---- drain and verdict ----
      req_tvalid <= 1'b0;
      repeat (2) @(posedge clock);
      while (bins_pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   // watchdog: far beyond the slowest legal run
   initial begin
      #8000000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
